>>> sv/bpc_pkg.sv
package bpc_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_A0  = 3'd0;
  localparam logic [2:0] REG_B1  = 3'd1;
  localparam logic [2:0] REG_B2  = 3'd2;
  localparam logic [2:0] REG_C12 = 3'd3;
  localparam logic [2:0] REG_C11 = 3'd4;
  localparam logic [2:0] REG_C22 = 3'd5;

  localparam int CFG_IDX_W  = 3;
  localparam int COEF_W     = 16;
  localparam int RAW_W      = 16;
  localparam int ADC_W      = 10;
  localparam int ADC_LSB    = 6;
  localparam int KPA_W      = 15;

  // Intermediate widths, sized from the coefficient and count ranges
  localparam int A11_W  = 18;
  localparam int A1_W   = 18;
  localparam int A2_W   = 17;
  localparam int Y1_W   = 18;
  localparam int PC_W   = 27;  // coefficient times count
  localparam int PA1_W  = 28;  // a1 times count
  localparam int PA2_W  = 27;  // a2 times count
  localparam int CNT_MAX = 1023;

  // kPa mapping: 12800 + round(16640 * c / 1023)
  //   = 12800 + 16 * c + floor((272 * c + 511) / 1023)
  localparam int KPA_BASE      = 12800;
  localparam int KPA_STEP      = 16;
  localparam int KPA_FRAC_MUL  = 272;
  localparam int KPA_BIAS      = 511;
  localparam int KPA_DIV       = 1023;
  localparam int KPA_RECIP     = 1025;  // floor(2^20 / 1023)
  localparam int KPA_RSHIFT    = 20;
  localparam int KPA_T_W       = 19;
  localparam int KPA_PROD_W    = 29;
  localparam int KPA_Q_W       = 9;

  typedef struct packed {
    logic signed [COEF_W-1:0] a0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] c12;
    logic signed [COEF_W-1:0] c11;
    logic signed [COEF_W-1:0] c22;
  } coef_t;

  typedef struct packed {
    logic [ADC_W-1:0] count;
    logic             clamped;
  } cnt_t;

endpackage

>>> sv/bpc_poly.sv
module bpc_poly
  import bpc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  coef_t            coef,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [RAW_W-1:0] raw_pressure,
  input  logic [RAW_W-1:0] raw_temperature,
  output logic             out_valid,
  input  logic             out_ready,
  output cnt_t             out_cnt
);

  localparam int NS = 6;

  logic [NS-1:0] v;
  logic [NS-1:0] adv;

  // Stage 0: counts and the three count products
  logic [ADC_W-1:0]       s0_padc, s0_tadc;
  logic signed [PC_W-1:0] s0_p11, s0_p12, s0_p22;
  // Stage 1: a11 and a2
  logic [ADC_W-1:0]        s1_padc, s1_tadc;
  logic signed [PC_W-1:0]  s1_p12;
  logic signed [A11_W-1:0] s1_a11;
  logic signed [A2_W-1:0]  s1_a2;
  // Stage 2: a1 and a2 * Tadc
  logic [ADC_W-1:0]        s2_padc;
  logic signed [A1_W-1:0]  s2_a1;
  logic signed [PA2_W-1:0] s2_pa2;
  // Stage 3: a1 * Padc
  logic signed [PA1_W-1:0] s3_pa1;
  logic signed [PA2_W-1:0] s3_pa2;
  // Stage 4: y1
  logic signed [Y1_W-1:0]  s4_y1;
  logic signed [PA2_W-1:0] s4_pa2;
  // Stage 5: clamped count
  cnt_t s5_cnt;

  logic [ADC_W-1:0]        padc_next, tadc_next;
  logic signed [A11_W-1:0] a11_next;
  logic signed [A2_W-1:0]  a2_next;
  logic signed [A1_W-1:0]  a1_next;
  logic signed [Y1_W-1:0]  y1_next;
  logic signed [31:0]      sum_cnt;
  logic signed [15:0]      raw_cnt;
  cnt_t                    cnt_next;

  // A stage loads when empty or when the stage after it moves on
  always_comb begin
    adv[NS-1] = !v[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v[NS-1];
  assign out_cnt   = s5_cnt;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign padc_next = raw_pressure[RAW_W-1:ADC_LSB];
  assign tadc_next = raw_temperature[RAW_W-1:ADC_LSB];

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0_padc <= padc_next;
      s0_tadc <= tadc_next;
      s0_p11  <= coef.c11 * $signed({1'b0, padc_next});
      s0_p12  <= coef.c12 * $signed({1'b0, tadc_next});
      s0_p22  <= coef.c22 * $signed({1'b0, tadc_next});
    end
  end

  // a11 = (b1 * 2^14 + c11 * Padc) >> 14, a2 = (b2 * 2^15 + (c22 * Tadc >> 1)) >> 16
  always_comb begin
    a11_next = A11_W'(((32'(coef.b1) <<< 14) + 32'(s0_p11)) >>> 14);
    a2_next  = A2_W'(((32'(coef.b2) <<< 15) + 32'(s0_p22 >>> 1)) >>> 16);
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_padc <= s0_padc;
      s1_tadc <= s0_tadc;
      s1_p12  <= s0_p12;
      s1_a11  <= a11_next;
      s1_a2   <= a2_next;
    end
  end

  // a1 = (a11 * 2^11 + c12 * Tadc) >> 11
  assign a1_next = A1_W'(((32'(s1_a11) <<< 11) + 32'(s1_p12)) >>> 11);

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_padc <= s1_padc;
      s2_a1   <= a1_next;
      s2_pa2  <= s1_a2 * $signed({1'b0, s1_tadc});
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_pa1 <= s2_a1 * $signed({1'b0, s2_padc});
      s3_pa2 <= s2_pa2;
    end
  end

  // y1 = (a0 * 2^10 + a1 * Padc) >> 10
  assign y1_next = Y1_W'(((32'(coef.a0) <<< 10) + 32'(s3_pa1)) >>> 10);

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_y1  <= y1_next;
      s4_pa2 <= s3_pa2;
    end
  end

  // Final count keeps bits 28..13 of the sum, then clamp to 0..1023
  always_comb begin
    sum_cnt  = (32'(s4_y1) <<< 10) + 32'(s4_pa2);
    raw_cnt  = sum_cnt[28:13];
    cnt_next = '{count: raw_cnt[ADC_W-1:0], clamped: 1'b0};
    if (raw_cnt[15]) begin
      cnt_next = '{count: '0, clamped: 1'b1};
    end else if (raw_cnt > 16'(CNT_MAX)) begin
      cnt_next = '{count: ADC_W'(CNT_MAX), clamped: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_cnt <= cnt_next;
    end
  end

endmodule

>>> sv/bpc_kpa.sv
module bpc_kpa
  import bpc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  cnt_t             in_cnt,
  output logic             out_valid,
  input  logic             out_ready,
  output cnt_t             out_cnt,
  output logic [KPA_W-1:0] out_kpa
);

  logic v0, v1;
  logic adv0, adv1;

  cnt_t               s0_cnt;
  logic [KPA_T_W-1:0] s0_t;
  logic [KPA_Q_W-1:0] s0_q0;

  cnt_t               s1_cnt;
  logic [KPA_W-1:0]   s1_kpa;

  logic [KPA_T_W-1:0]    t_next;
  logic [KPA_PROD_W-1:0] prod;
  logic [KPA_T_W-1:0]    rem;
  logic [KPA_Q_W-1:0]    q;
  logic [KPA_W-1:0]      kpa_next;

  assign adv1      = !v1 || out_ready;
  assign adv0      = !v0 || adv1;
  assign in_ready  = adv0;
  assign out_valid = v1;
  assign out_cnt   = s1_cnt;
  assign out_kpa   = s1_kpa;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      if (adv0) begin
        v0 <= in_valid;
      end
      if (adv1) begin
        v1 <= v0;
      end
    end
  end

  // Estimate floor(t / 1023) by reciprocal; low by at most one
  always_comb begin
    t_next = KPA_T_W'(KPA_FRAC_MUL * int'(in_cnt.count) + KPA_BIAS);
    prod   = KPA_PROD_W'(t_next) * KPA_PROD_W'(KPA_RECIP);
  end

  always_ff @(posedge clk) begin
    if (adv0) begin
      s0_cnt <= in_cnt;
      s0_t   <= t_next;
      s0_q0  <= KPA_Q_W'(prod >> KPA_RSHIFT);
    end
  end

  // Correct the quotient from the remainder and add the integer part
  always_comb begin
    rem      = s0_t - KPA_T_W'(s0_q0) * KPA_T_W'(KPA_DIV);
    q        = s0_q0 + KPA_Q_W'(rem >= KPA_T_W'(KPA_DIV));
    kpa_next = KPA_W'(KPA_BASE + KPA_STEP * int'(s0_cnt.count) + int'(q));
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_cnt <= s0_cnt;
      s1_kpa <= kpa_next;
    end
  end

endmodule

>>> sv/barometer_pressure_compensation_unit.sv
// Pipeline: an input transfer reaches its result through the six
// polynomial stages and the two stages of the kPa mapping.
// Throughput: one item per cycle unless the output stalls; each stage holds
// an item until the next stage frees up, so bubbles close up under output stall.
// Reset (rst, synchronous): empties the pipeline and clears all coefficients.
module barometer_pressure_compensation_unit
  import bpc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [RAW_W-1:0]     raw_pressure,
  input  logic [RAW_W-1:0]     raw_temperature,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ADC_W-1:0]     comp_count,
  output logic [KPA_W-1:0]     pressure_kpa_q8,
  output logic                 clamped
);

  coef_t coef;
  logic  mid_valid, mid_ready;
  cnt_t  mid_cnt;
  cnt_t  res_cnt;

  // Coefficient registers; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_A0:  coef.a0  <= cfg_data;
        REG_B1:  coef.b1  <= cfg_data;
        REG_B2:  coef.b2  <= cfg_data;
        REG_C12: coef.c12 <= cfg_data;
        REG_C11: coef.c11 <= cfg_data;
        REG_C22: coef.c22 <= cfg_data;
        default: ;
      endcase
    end
  end

  bpc_poly u_poly (
    .clk             (clk),
    .rst             (rst),
    .coef            (coef),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .raw_pressure    (raw_pressure),
    .raw_temperature (raw_temperature),
    .out_valid       (mid_valid),
    .out_ready       (mid_ready),
    .out_cnt         (mid_cnt)
  );

  bpc_kpa u_kpa (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_cnt    (mid_cnt),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_cnt   (res_cnt),
    .out_kpa   (pressure_kpa_q8)
  );

  assign comp_count = res_cnt.count;
  assign clamped    = res_cnt.clamped;

  // A clamped count sits at one of the two rails
  a_clamp_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && clamped |-> comp_count == '0 || comp_count == ADC_W'(CNT_MAX))
    else $error("clamped result not at a rail");

  // Pressure stays within the 50..115 kPa span
  a_kpa_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pressure_kpa_q8 >= KPA_W'(KPA_BASE)
               && pressure_kpa_q8 <= KPA_W'(KPA_BASE + 16640))
    else $error("pressure out of range");

  // A full-scale count maps to the top end of the span
  a_kpa_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && comp_count == ADC_W'(CNT_MAX)
      |-> pressure_kpa_q8 == KPA_W'(KPA_BASE + 16640))
    else $error("full-scale count mapped wrong");

endmodule

>>> tb/sv/pressure_scoreboard.sv
module pressure_scoreboard
  import bpc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]  cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [RAW_W-1:0]   raw_pressure,
  input  logic [RAW_W-1:0]   raw_temperature,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [ADC_W-1:0]   comp_count,
  input  logic [KPA_W-1:0]   pressure_kpa_q8,
  input  logic               clamped,
  output int                 mismatches,
  output int                 outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // Full-scale kPa span in Q8.8: 65 kPa * 256
  localparam int KPA_SPAN = 16640;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [ADC_W-1:0] count;
    logic [KPA_W-1:0] kpa;
    logic             clamped;
  } reading_t;

  coef_t    coefs;
  reading_t expected_readings[$];
  int       errors = 0;

  // Evaluate the compensation polynomial with 32-bit wrapping arithmetic
  function automatic reading_t compensate_reading(coef_t k, logic [RAW_W-1:0] p_raw,
                                                  logic [RAW_W-1:0] t_raw);
    int padc, tadc, a0, b1, b2, c12, c11, c22;
    int a11, a1, a2, y1, acc, cnt;
    logic signed [15:0] cnt16;
    reading_t r;
    padc = int'(p_raw[RAW_W-1:ADC_LSB]);
    tadc = int'(t_raw[RAW_W-1:ADC_LSB]);
    a0  = $signed(k.a0);
    b1  = $signed(k.b1);
    b2  = $signed(k.b2);
    c12 = $signed(k.c12);
    c11 = $signed(k.c11);
    c22 = $signed(k.c22);
    a11 = ((b1 << 14) + c11 * padc) >>> 14;
    a1  = ((a11 << 11) + c12 * tadc) >>> 11;
    a2  = ((b2 << 15) + ((c22 * tadc) >>> 1)) >>> 16;
    y1  = ((a0 << 10) + a1 * padc) >>> 10;
    acc = ((y1 << 10) + a2 * tadc) >>> 13;
    // keep the low 16 bits as a signed count, then clamp
    cnt16 = acc[15:0];
    cnt = cnt16;
    if (cnt < 0) begin
      r.count = '0;
      r.clamped = 1'b1;
    end else if (cnt > CNT_MAX) begin
      r.count = ADC_W'(CNT_MAX);
      r.clamped = 1'b1;
    end else begin
      r.count = cnt[ADC_W-1:0];
      r.clamped = 1'b0;
    end
    cnt = int'(r.count);
    r.kpa = KPA_W'(KPA_BASE + (2 * KPA_SPAN * cnt + KPA_DIV) / (2 * KPA_DIV));
    return r;
  endfunction

  // Track coefficient writes, queue predictions, compare each result transfer
  always @(posedge clk) begin
    reading_t want, got;
    if (rst) begin
      coefs = '0;
      expected_readings.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_A0:  coefs.a0  = cfg_data;
          REG_B1:  coefs.b1  = cfg_data;
          REG_B2:  coefs.b2  = cfg_data;
          REG_C12: coefs.c12 = cfg_data;
          REG_C11: coefs.c11 = cfg_data;
          REG_C22: coefs.c22 = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_readings.push_back(compensate_reading(coefs, raw_pressure, raw_temperature));
      if (out_valid && out_ready) begin
        got = '{comp_count, pressure_kpa_q8, clamped};
        if (expected_readings.size() == 0) begin
          if (errors < MAX_REPORTS)
            $display("%0t: unexpected result count %0d kpa %0d clamped %0b",
                     $realtime, got.count, got.kpa, got.clamped);
          errors++;
        end else begin
          want = expected_readings.pop_front();
          if (got !== want) begin
            if (errors < MAX_REPORTS)
              $display("%0t: mismatch: expected count %0d kpa %0d clamped %0b,",
                       $realtime, want.count, want.kpa, want.clamped,
                       " got count %0d kpa %0d clamped %0b",
                       got.count, got.kpa, got.clamped);
            errors++;
          end
        end
      end
    end
    mismatches <= errors;
    outstanding <= expected_readings.size();
  end

endmodule

>>> tb/sv/testbench.sv
module testbench;
  import bpc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 12;   // a little over the pipeline latency
  localparam int PHASES = 12;
  localparam int ITEMS_PER_PHASE = 96;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED7 = 3'd7;

  // Typical factory trim for this sensor family
  localparam logic [COEF_W-1:0] TYP_A0  = 16'h3ECE;
  localparam logic [COEF_W-1:0] TYP_B1  = 16'hB3F9;
  localparam logic [COEF_W-1:0] TYP_B2  = 16'hC517;
  localparam logic [COEF_W-1:0] TYP_C12 = 16'h33C8;
  localparam logic [COEF_W-1:0] UNITY_B1 = 16'h2000;  // 1.0 with 13 fraction bits

  typedef enum {
    CFG_IDENTITY, CFG_OFFSET, CFG_TYPICAL, CFG_NEAR_TYPICAL,
    CFG_RANDOM, CFG_CORNERS, CFG_ALL_MAX, CFG_ALL_MIN
  } cfg_style_e;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [RAW_W-1:0]     raw_pressure = '0;
  logic [RAW_W-1:0]     raw_temperature = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [ADC_W-1:0]     comp_count;
  logic [KPA_W-1:0]     pressure_kpa_q8;
  logic                 clamped;
  int                   mismatches;
  int                   outstanding;
  int                   cycles = 0;
  bit                   in_steady = 1'b0;
  bit                   out_steady = 1'b0;

  barometer_pressure_compensation_unit dut (.*);

  pressure_scoreboard scoreboard (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL barometer_pressure_compensation_unit");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [COEF_W-1:0] pick_corner();
    case ($urandom_range(0, 3))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] jitter(logic [COEF_W-1:0] base, int span);
    return base + COEF_W'($urandom_range(0, 2 * span) - span);
  endfunction

  function automatic coef_t pick_coefs(cfg_style_e style);
    coef_t c;
    c = '0;
    case (style)
      CFG_IDENTITY: c.b1 = UNITY_B1;
      CFG_OFFSET: begin
        c.b1  = UNITY_B1;
        c.a0  = jitter(16'h0000, 2048);
        c.c12 = jitter(16'h0000, 64);
      end
      CFG_TYPICAL: begin
        c.a0 = TYP_A0;
        c.b1 = TYP_B1;
        c.b2 = TYP_B2;
        c.c12 = TYP_C12;
      end
      CFG_NEAR_TYPICAL: begin
        c.a0  = jitter(TYP_A0, 1024);
        c.b1  = jitter(TYP_B1, 512);
        c.b2  = jitter(TYP_B2, 512);
        c.c12 = jitter(TYP_C12, 512);
        c.c11 = jitter(16'h0000, 128);
        c.c22 = jitter(16'h0000, 128);
      end
      CFG_RANDOM: c = coef_t'({$urandom, $urandom, $urandom});
      CFG_CORNERS: begin
        c.a0 = pick_corner();
        c.b1 = pick_corner();
        c.b2 = pick_corner();
        c.c12 = pick_corner();
        c.c11 = pick_corner();
        c.c22 = pick_corner();
      end
      CFG_ALL_MAX: c = {6{16'h7FFF}};
      CFG_ALL_MIN: c = {6{16'h8000}};
      default: ;
    endcase
    return c;
  endfunction

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
  endtask

  // Write all coefficients, then hit the unused indexes to check they alias nothing
  task automatic load_coefs(coef_t c);
    put_reg(REG_A0, c.a0);
    put_reg(REG_B1, c.b1);
    put_reg(REG_B2, c.b2);
    put_reg(REG_C12, c.c12);
    put_reg(REG_C11, c.c11);
    put_reg(REG_C22, c.c22);
    put_reg(REG_UNUSED6, COEF_W'($urandom));
    put_reg(REG_UNUSED7, COEF_W'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Present one reading and hold it until the transfer
  task automatic send_reading(logic [RAW_W-1:0] p_raw, logic [RAW_W-1:0] t_raw);
    int gap;
    gap = in_steady ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    raw_pressure <= p_raw;
    raw_temperature <= t_raw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid and wait for every pending result to come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result-side back-pressure
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        stall = out_steady ? 0 : pick_gap();
      end
    end
  end

  initial begin
    cfg_style_e style;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // Coefficients straight out of reset
    send_reading(16'h0000, 16'h0000);
    send_reading(16'hFFFF, 16'hFFFF);
    drain();

    // Typical trim with corner raw words
    load_coefs(pick_coefs(CFG_TYPICAL));
    send_reading(16'h0000, 16'hFFFF);
    send_reading(16'hFFFF, 16'h0000);
    send_reading(16'h003F, 16'h003F);
    send_reading(16'hFFC0, 16'hFFC0);
    send_reading(16'h8000, 16'h7FFF);
    send_reading(16'h7FFF, 16'h8000);
    send_reading(16'h1980, 16'h1F80);
    drain();

    // Saturated coefficients: wrapping chain and both clamp directions
    load_coefs(pick_coefs(CFG_ALL_MAX));
    send_reading(16'hFFFF, 16'hFFFF);
    send_reading(16'h0000, 16'h0000);
    send_reading(16'hFFFF, 16'h0000);
    drain();
    load_coefs(pick_coefs(CFG_ALL_MIN));
    send_reading(16'hFFFF, 16'hFFFF);
    send_reading(16'h0000, 16'h0000);
    send_reading(16'h0000, 16'hFFFF);
    drain();

    // Unity slope: count follows the pressure word, both ends of the range
    load_coefs(pick_coefs(CFG_IDENTITY));
    send_reading(16'h0000, 16'hFFFF);
    send_reading(16'hFFC0, 16'h0000);
    send_reading(16'h7FC0, 16'h1234);
    drain();

    // Random readings over a rotation of coefficient sets
    style = style.first();
    for (int ph = 0; ph < PHASES; ph++) begin
      load_coefs(pick_coefs(style));
      in_steady = ($urandom_range(0, 4) == 0);
      out_steady = ($urandom_range(0, 4) == 0);
      repeat (ITEMS_PER_PHASE) send_reading(RAW_W'($urandom), RAW_W'($urandom));
      drain();
      style = style.next();
    end

    if (mismatches == 0)
      $display("PASS barometer_pressure_compensation_unit");
    else
      $display("FAIL barometer_pressure_compensation_unit");
    $finish;
  end

endmodule

>>> sim.f
sv/bpc_pkg.sv
sv/bpc_poly.sv
sv/bpc_kpa.sv
sv/barometer_pressure_compensation_unit.sv
tb/sv/pressure_scoreboard.sv
tb/sv/testbench.sv
